// File: rtl/ictab_pkg.sv
`default_nettype none

package ictab_pkg;

  // Item modes, echoed as result kind
  localparam logic [1:0] MODE_RESEED = 2'd0;
  localparam logic [1:0] MODE_WRITE  = 2'd1;
  localparam logic [1:0] MODE_DRAW   = 2'd2;
  localparam logic [1:0] MODE_RAW    = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_SEED  = 2'd0;
  localparam logic [1:0] CFG_TLEN  = 2'd1;
  localparam logic [1:0] CFG_BASE  = 2'd2;

  // splitmix64 constants
  localparam logic [63:0] SM_GOLDEN = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] SM_MUL_A  = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] SM_MUL_B  = 64'h94d049bb133111eb;
  localparam int unsigned SM_SH_A   = 30;
  localparam int unsigned SM_SH_B   = 27;
  localparam int unsigned SM_SH_C   = 31;

  // xoshiro256** constants
  localparam int unsigned XO_SHL    = 17;
  localparam int unsigned XO_ROT_S  = 45;
  localparam int unsigned XO_ROT_O  = 7;

  // Fraction taken from the top of the random word
  localparam int unsigned FRAC_SHIFT = 11;

  // Width for table lengths and depths (depth may reach 65536)
  localparam int unsigned LEN_W = 17;

  typedef struct packed {
    logic [1:0]  mode;
    logic [9:0]  entry_index;
    logic [53:0] entry_value;
  } in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [16:0] sample_value;
    logic [63:0] random_word;
  } out_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SM_ADD,
    OP_SM_MIX1,
    OP_MUL0,
    OP_MUL1,
    OP_MUL2,
    OP_SM_MIX2,
    OP_SM_FIN,
    OP_WR_ENTRY,
    OP_GEN_STEP,
    OP_GEN_OUT,
    OP_SRCH_RD,
    OP_SRCH_CMP,
    OP_LOAD_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       mul_b_sel;
    logic [1:0] word_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic srch_done;
  } dp_sts_t;

  function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned n);
    return (v << n) | (v >> (64 - n));
  endfunction

endpackage

`default_nettype wire

// File: rtl/ictab_ctrl.sv
`default_nettype none

module ictab_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic [1:0]          in_mode,
  output logic                     in_stall,
  input  wire logic                out_stall,
  output logic                     out_valid,
  output ictab_pkg::dp_cmd_t       cmd,
  input  wire ictab_pkg::dp_sts_t  sts
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_SM_ADD,
    S_SM_MIX1,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_SM_MIX2,
    S_SM_FIN,
    S_WR,
    S_GEN_STEP,
    S_GEN_OUT,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_OUT
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] mode_r, mode_nxt;
  logic [1:0] wi_r, wi_nxt;
  logic       second_r, second_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Take a new item only between items
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // Sequence the datapath
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    wi_nxt        = wi_r;
    second_nxt    = second_r;
    out_valid_nxt = out_valid_r & out_stall;
    cmd.op        = ictab_pkg::OP_NONE;
    cmd.mul_b_sel = second_r;
    cmd.word_sel  = wi_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = ictab_pkg::OP_LOAD;
          mode_nxt   = in_mode;
          wi_nxt     = 2'd0;
          second_nxt = 1'b0;
          case (in_mode)
            ictab_pkg::MODE_RESEED: state_nxt = S_SM_ADD;
            ictab_pkg::MODE_WRITE:  state_nxt = S_WR;
            default:                state_nxt = S_GEN_STEP;
          endcase
        end
      end
      S_SM_ADD: begin
        cmd.op    = ictab_pkg::OP_SM_ADD;
        state_nxt = S_SM_MIX1;
      end
      S_SM_MIX1: begin
        cmd.op    = ictab_pkg::OP_SM_MIX1;
        state_nxt = S_MUL0;
      end
      S_MUL0: begin
        cmd.op    = ictab_pkg::OP_MUL0;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.op    = ictab_pkg::OP_MUL1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.op    = ictab_pkg::OP_MUL2;
        state_nxt = second_r ? S_SM_FIN : S_SM_MIX2;
      end
      S_SM_MIX2: begin
        cmd.op     = ictab_pkg::OP_SM_MIX2;
        second_nxt = 1'b1;
        state_nxt  = S_MUL0;
      end
      S_SM_FIN: begin
        cmd.op     = ictab_pkg::OP_SM_FIN;
        second_nxt = 1'b0;
        wi_nxt     = wi_r + 2'd1;
        state_nxt  = (wi_r == 2'd3) ? S_OUT : S_SM_ADD;
      end
      S_WR: begin
        cmd.op    = ictab_pkg::OP_WR_ENTRY;
        state_nxt = S_OUT;
      end
      S_GEN_STEP: begin
        cmd.op    = ictab_pkg::OP_GEN_STEP;
        state_nxt = S_GEN_OUT;
      end
      S_GEN_OUT: begin
        cmd.op    = ictab_pkg::OP_GEN_OUT;
        state_nxt = (mode_r == ictab_pkg::MODE_DRAW) ? S_SRCH_RD : S_OUT;
      end
      S_SRCH_RD: begin
        if (sts.srch_done) begin
          state_nxt = S_OUT;
        end else begin
          cmd.op    = ictab_pkg::OP_SRCH_RD;
          state_nxt = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        cmd.op    = ictab_pkg::OP_SRCH_CMP;
        state_nxt = S_SRCH_RD;
      end
      S_OUT: begin
        // Hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          cmd.op        = ictab_pkg::OP_LOAD_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= ictab_pkg::MODE_RESEED;
      wi_r        <= 2'd0;
      second_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      wi_r        <= wi_nxt;
      second_r    <= second_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ictab_dp.sv
`default_nettype none

module ictab_dp #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [63:0]         cfg_data,
  input  wire ictab_pkg::in_t      in_data,
  input  wire ictab_pkg::dp_cmd_t  cmd,
  output ictab_pkg::dp_sts_t       sts,
  output ictab_pkg::out_t          out_data
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

  // Configuration registers
  logic [63:0] seed_r;
  logic [10:0] tlen_r;
  logic [15:0] base_r;

  // Item and working registers
  ictab_pkg::in_t  in_r;
  ictab_pkg::out_t out_r;
  logic [63:0] sv_r, z_r, acc_r, t_r, word_r;
  logic [63:0] gw_r [4];
  logic [IDX_W-1:0] lo_r, hi_r, mid_r;
  logic [53:0] rd_r;
  logic [53:0] mem [TABLE_DEPTH];

  // Shared 32x32 multiplier for the splitmix products
  logic [63:0] mul_b;
  logic [31:0] mul_x, mul_y;
  logic [63:0] prod;

  assign mul_b = cmd.mul_b_sel ? ictab_pkg::SM_MUL_B : ictab_pkg::SM_MUL_A;
  assign mul_x = (cmd.op == ictab_pkg::OP_MUL2) ? z_r[63:32] : z_r[31:0];
  assign mul_y = (cmd.op == ictab_pkg::OP_MUL1) ? mul_b[63:32] : mul_b[31:0];
  assign prod  = {32'd0, mul_x} * {32'd0, mul_y};

  // xoshiro256** state update
  logic [63:0] n0, n1, n2, n3;
  always_comb begin
    n2 = gw_r[2] ^ gw_r[0];
    n3 = gw_r[3] ^ gw_r[1];
    n1 = gw_r[1] ^ n2;
    n0 = gw_r[0] ^ n3;
    n2 = n2 ^ (gw_r[1] << ictab_pkg::XO_SHL);
    n3 = ictab_pkg::rotl64(n3, ictab_pkg::XO_ROT_S);
  end

  // Search bounds and midpoint
  logic [ictab_pkg::LEN_W-1:0] tl_ext, n_len, hi_ext;
  logic [IDX_W-1:0]            hi_init, mid;
  logic [IDX_W:0]              mid_sum;
  logic                        frac_above;

  always_comb begin
    tl_ext = ictab_pkg::LEN_W'(tlen_r);
    if (tl_ext == '0) begin
      n_len = ictab_pkg::LEN_W'(1);
    end else if (tl_ext > ictab_pkg::LEN_W'(TABLE_DEPTH)) begin
      n_len = ictab_pkg::LEN_W'(TABLE_DEPTH);
    end else begin
      n_len = tl_ext;
    end
    hi_ext  = n_len - ictab_pkg::LEN_W'(1);
    hi_init = hi_ext[IDX_W-1:0];
  end

  assign mid_sum    = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid        = mid_sum[IDX_W:1];
  assign frac_above = rd_r < {1'b0, word_r[63:ictab_pkg::FRAC_SHIFT]};

  assign sts.srch_done = (lo_r >= hi_r);

  // Table write gate
  logic             wr_ok;
  logic [IDX_W-1:0] wr_addr;
  assign wr_ok   = ictab_pkg::LEN_W'(in_r.entry_index) < ictab_pkg::LEN_W'(TABLE_DEPTH);
  assign wr_addr = IDX_W'(in_r.entry_index);

  // Configuration writes and generator words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
      tlen_r <= 11'd1;
      base_r <= '0;
      for (int i = 0; i < 4; i++) begin
        gw_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ictab_pkg::CFG_SEED: seed_r <= cfg_data;
          ictab_pkg::CFG_TLEN: tlen_r <= cfg_data[10:0];
          ictab_pkg::CFG_BASE: base_r <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (cmd.op == ictab_pkg::OP_SM_FIN) begin
        gw_r[cmd.word_sel] <= acc_r ^ (acc_r >> ictab_pkg::SM_SH_C);
      end else if (cmd.op == ictab_pkg::OP_GEN_STEP) begin
        gw_r[0] <= n0;
        gw_r[1] <= n1;
        gw_r[2] <= n2;
        gw_r[3] <= n3;
      end
    end
  end

  // Working registers, advanced by command
  always_ff @(posedge clk) begin
    case (cmd.op)
      ictab_pkg::OP_LOAD: begin
        in_r <= in_data;
        sv_r <= seed_r;
      end
      ictab_pkg::OP_SM_ADD:  sv_r  <= sv_r + ictab_pkg::SM_GOLDEN;
      ictab_pkg::OP_SM_MIX1: z_r   <= sv_r ^ (sv_r >> ictab_pkg::SM_SH_A);
      ictab_pkg::OP_MUL0:    acc_r <= prod;
      ictab_pkg::OP_MUL1,
      ictab_pkg::OP_MUL2:    acc_r <= acc_r + {prod[31:0], 32'd0};
      ictab_pkg::OP_SM_MIX2: z_r   <= acc_r ^ (acc_r >> ictab_pkg::SM_SH_B);
      ictab_pkg::OP_GEN_STEP: begin
        t_r <= ictab_pkg::rotl64(gw_r[1] + (gw_r[1] << 2), ictab_pkg::XO_ROT_O);
      end
      ictab_pkg::OP_GEN_OUT: begin
        word_r <= t_r + (t_r << 3);
        lo_r   <= '0;
        hi_r   <= hi_init;
      end
      ictab_pkg::OP_SRCH_RD: mid_r <= mid;
      ictab_pkg::OP_SRCH_CMP: begin
        if (frac_above) begin
          lo_r <= mid_r + IDX_W'(1);
        end else begin
          hi_r <= mid_r;
        end
      end
      ictab_pkg::OP_LOAD_OUT: begin
        out_r.result_kind  <= in_r.mode;
        out_r.sample_value <= (in_r.mode == ictab_pkg::MODE_DRAW)
                              ? (17'(base_r) + 17'(lo_r)) : 17'd0;
        out_r.random_word  <= (in_r.mode == ictab_pkg::MODE_DRAW ||
                               in_r.mode == ictab_pkg::MODE_RAW) ? word_r : 64'd0;
      end
      default: ;
    endcase
  end

  // CDF table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.op == ictab_pkg::OP_WR_ENTRY && wr_ok) begin
      mem[wr_addr] <= in_r.entry_value;
    end
    if (cmd.op == ictab_pkg::OP_SRCH_RD) begin
      rd_r <= mem[mid];
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

// File: rtl/inverse_cdf_table_sampler.sv
`default_nettype none

// Discrete sampler by inverse transform over a loaded CDF table.
// Input channel in_valid/in_stall/in_data: each beat carries a mode. Reseed
// expands the configured seed into the xoshiro256** state with four splitmix64 steps;
// write stores entry_value at entry_index; draw takes one generator word,
// binary-searches the table with its top 53 bits and returns base plus index;
// raw returns one generator word. Every beat gives exactly one result beat on
// out_valid/out_stall/out_data, in order.
// Configuration port cfg_valid/cfg_ready/cfg_index/cfg_data: index 0 seed,
// 1 table length, 2 base value. cfg_ready is always high; write only while
// the block is idle.
// A draw probes the table through its single registered read port, one read
// and one compare per probe; a reseed uses the shared 32x32 multiplier, three
// passes per 64-bit product. After each result the block returns to the idle
// state, which takes the next beat. One item is in work at a time; the next
// is taken as soon as the result sits in the output register, even while
// out_stall holds it.
// Reset (rst_n low, synchronous) clears the generator to zero, the registers
// to seed 0, length 1, base 0; the table holds garbage until written.

module inverse_cdf_table_sampler #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire ictab_pkg::in_t   in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output ictab_pkg::out_t       out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [63:0]      cfg_data
);

  ictab_pkg::dp_cmd_t cmd;
  ictab_pkg::dp_sts_t sts;

  assign cfg_ready = 1'b1;

  ictab_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_data.mode),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  ictab_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
